### hw/rtl/ncs_pkg.sv
// ============================================================================
// ncs_pkg
// shared types and constants of the nearest cell search block
// ============================================================================
package ncs_pkg;

  localparam int CELL_W  = 12;
  localparam int DIST_W  = 50;
  localparam int TOL_W   = 21;
  localparam int NUMC_W  = 13;
  localparam int CNT_W   = 9;
  localparam int XC_W    = 32;

  localparam int MAX_CELLS_DEF      = 4096;
  localparam int MAX_NEIGHBOURS_DEF = 32;
  localparam int MAX_TIES_DEF       = 64;
  localparam int COORD_BITS_DEF     = 24;

  localparam logic [1:0] REQ_WR_POINT = 2'd0;
  localparam logic [1:0] REQ_WR_NB    = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;

  localparam logic CFG_NUM_CELLS = 1'b0;
  localparam logic CFG_TIE_TOL   = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [1:0]        req_type;
    logic [11:0]       cell_req;
    logic [4:0]        slot;
    logic [11:0]       neighbour;
    logic [5:0]        neighbour_count;
    logic              use_guess;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
  } in_beat_t;

  typedef struct packed {
    logic [11:0]       closest_cell;
    logic [DIST_W-1:0] min_distance;
    logic              found;
    logic              overflow;
    logic              is_last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CELL_W-1:0]  cid;
    logic [4:0]         slot;
    logic [CELL_W-1:0]  nb;
    logic [CNT_W-1:0]   cnt;
    logic               guess;
    logic signed [XC_W-1:0] x;
    logic signed [XC_W-1:0] y;
    logic signed [XC_W-1:0] z;
  } cmd_t;

endpackage

### hw/rtl/ncs_front.sv
// ============================================================================
// ncs_front
// input stage: takes beats, drops unused request codes, builds commands
// ============================================================================
module ncs_front #(
  parameter int MAX_NEIGHBOURS = ncs_pkg::MAX_NEIGHBOURS_DEF,
  parameter int COORD_BITS     = ncs_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ncs_pkg::in_beat_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_full,
  output ncs_pkg::cmd_t    cmd
);
  import ncs_pkg::*;

  localparam int SH = XC_W - COORD_BITS;

  logic  valid_r, valid_nxt;
  cmd_t  cmd_r;
  cmd_t  cmd_nxt;
  logic  take;

  function automatic logic signed [XC_W-1:0] sext(input logic [23:0] v);
    logic [XC_W-1:0] e;
    e = XC_W'(v) << SH;
    return $signed(e) >>> SH;
  endfunction

  assign in_stall  = valid_r && cmd_full;
  assign take      = in_valid && !in_stall;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.kind  = in_data.req_type;
    cmd_nxt.cid   = in_data.cell_req;
    cmd_nxt.slot  = in_data.slot;
    cmd_nxt.nb    = in_data.neighbour;
    cmd_nxt.cnt   = (32'(in_data.neighbour_count) > MAX_NEIGHBOURS) ?
                    CNT_W'(MAX_NEIGHBOURS) : CNT_W'(in_data.neighbour_count);
    cmd_nxt.guess = in_data.use_guess;
    cmd_nxt.x     = sext(in_data.coord_x);
    cmd_nxt.y     = sext(in_data.coord_y);
    cmd_nxt.z     = sext(in_data.coord_z);
    valid_nxt = valid_r && cmd_full;
    if (take) begin
      valid_nxt = (in_data.req_type == REQ_WR_POINT) || (in_data.req_type == REQ_WR_NB) ||
                  (in_data.req_type == REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### hw/rtl/ncs_fifo.sv
// ============================================================================
// ncs_fifo
// two-entry command queue between front and back
// ============================================================================
module ncs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### hw/rtl/ncs_back.sv
// ============================================================================
// ncs_back
// store updates, distance scan pipeline, tie tracking and result output
// ============================================================================
module ncs_back #(
  parameter int MAX_CELLS      = ncs_pkg::MAX_CELLS_DEF,
  parameter int MAX_NEIGHBOURS = ncs_pkg::MAX_NEIGHBOURS_DEF,
  parameter int MAX_TIES       = ncs_pkg::MAX_TIES_DEF,
  parameter int COORD_BITS     = ncs_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_empty,
  input  ncs_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic [ncs_pkg::NUMC_W-1:0] num_cells,
  input  logic [ncs_pkg::TOL_W-1:0]  tie_tol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ncs_pkg::out_beat_t         out_data
);
  import ncs_pkg::*;

  localparam int CAW = $clog2(MAX_CELLS);
  localparam int CW  = (CAW > CELL_W) ? CAW : CELL_W;
  localparam int SW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int NCW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int IW0 = $clog2(MAX_CELLS + 1);
  localparam int IW  = (IW0 > NCW) ? IW0 : NCW;
  localparam int TW  = $clog2(MAX_TIES + 1);
  localparam int TAW = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
  localparam int CB  = COORD_BITS;
  localparam int AW  = CB + 1;
  localparam int SQ  = 25;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CNT   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_EMRD  = 3'd5;
  localparam logic [2:0] ST_EMLD  = 3'd6;
  localparam logic [2:0] ST_NONE  = 3'd7;

  // stores
  logic [3*CB-1:0] pt_mem  [MAX_CELLS];
  logic [CELL_W-1:0] nb_mem [2**(CAW+SW)];
  logic [NCW-1:0]  cnt_mem [MAX_CELLS];
  logic [CELL_W-1:0] tb_mem [2**TAW];

  logic [2:0]      state_r, state_nxt;
  logic [CAW-1:0]  clr_r;
  logic [IW-1:0]   i_r, n_r;
  logic            guess_r, gok_r;
  logic [CAW-1:0]  gcell_r;
  logic [CB-1:0]   tx_r, ty_r, tz_r;
  logic [IW-1:0]   lim;

  logic            a_v_r, a_nb_r;
  logic [CW-1:0]   a_cell_r;
  logic [CELL_W-1:0] nb_q_r;
  logic [NCW-1:0]  cnt_q_r;
  logic            b_v_r;
  logic [CW-1:0]   b_cell_r;
  logic [3*CB-1:0] pt_q_r;
  logic            c_v_r, c_sat_r;
  logic [CW-1:0]   c_cell_r;
  logic [AW-1:0]   c_ax_r, c_ay_r, c_az_r;
  logic            d_v_r, d_sat_r;
  logic [CW-1:0]   d_cell_r;
  logic [2*SQ-1:0] d_sx_r, d_sy_r, d_sz_r;
  logic            e_v_r;
  logic [CW-1:0]   e_cell_r;
  logic [DIST_W-1:0] e_d_r;

  logic [DIST_W-1:0] best_r;
  logic [TW-1:0]   tcnt_r;
  logic            ovf_r;
  logic [TW-1:0]   em_r;
  logic [CELL_W-1:0] tb_q_r;
  out_beat_t       out_r;
  logic            out_valid_r;
  logic            out_free;

  logic [CW-1:0]   b_cell;
  logic            b_ok;
  logic            issue;
  logic signed [AW-1:0] dx, dy, dz;
  logic [AW-1:0]   ax, ay, az;
  logic [DIST_W+1:0] sum;
  logic [DIST_W-1:0] diff;
  logic            tie, less;
  logic            tb_we;
  logic [TAW-1:0]  tb_wa;
  logic            restart;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
  assign lim       = guess_r ? (gok_r ? IW'(cnt_q_r) : IW'(0)) : n_r;
  assign issue     = (state_r == ST_SCAN) && (i_r < lim);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (32'(clr_r) == MAX_CELLS - 1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cmd_pop && cmd.kind == REQ_QUERY) begin
          state_nxt = cmd.guess ? ST_CNT : ST_SCAN;
        end
      end
      ST_CNT:   state_nxt = ST_SCAN;
      ST_SCAN:  if (!issue) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (!a_v_r && !b_v_r && !c_v_r && !d_v_r && !e_v_r) begin
          state_nxt = (tcnt_r == '0) ? ST_NONE : ST_EMRD;
        end
      end
      ST_EMRD:  state_nxt = ST_EMLD;
      ST_EMLD: begin
        if (out_free) state_nxt = (em_r + TW'(1) == tcnt_r) ? ST_IDLE : ST_EMRD;
      end
      ST_NONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // candidate selection, range check, absolute differences and sum of squares
  always_comb begin
    b_cell = a_nb_r ? CW'(nb_q_r) : a_cell_r;
    b_ok   = 32'(b_cell) < MAX_CELLS;
    dx = $signed({pt_q_r[CB-1], pt_q_r[CB-1:0]}) - $signed({tx_r[CB-1], tx_r});
    dy = $signed({pt_q_r[2*CB-1], pt_q_r[2*CB-1:CB]}) - $signed({ty_r[CB-1], ty_r});
    dz = $signed({pt_q_r[3*CB-1], pt_q_r[3*CB-1:2*CB]}) - $signed({tz_r[CB-1], tz_r});
    ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
    ay = dy[AW-1] ? AW'(-dy) : AW'(dy);
    az = dz[AW-1] ? AW'(-dz) : AW'(dz);
    sum = (DIST_W+2)'(d_sx_r) + (DIST_W+2)'(d_sy_r) + (DIST_W+2)'(d_sz_r);
  end

  // tie tracking
  always_comb begin
    diff    = (e_d_r > best_r) ? e_d_r - best_r : best_r - e_d_r;
    tie     = diff < DIST_W'(tie_tol);
    less    = e_d_r < best_r;
    restart = e_v_r && ((tcnt_r == '0) || (!tie && less));
    tb_we   = 1'b0;
    tb_wa   = '0;
    if (restart) begin
      tb_we = 1'b1;
    end else if (e_v_r && tie && 32'(tcnt_r) < MAX_TIES) begin
      tb_we = 1'b1;
      tb_wa = TAW'(tcnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      tcnt_r      <= '0;
      ovf_r       <= 1'b0;
      best_r      <= DIST_MAX;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + CAW'(1);
      a_v_r <= issue || (state_r == ST_CNT && gok_r);
      b_v_r <= a_v_r && b_ok;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      if (cmd_pop && cmd.kind == REQ_QUERY) begin
        tcnt_r <= '0;
        ovf_r  <= 1'b0;
        best_r <= DIST_MAX;
      end else if (restart) begin
        tcnt_r <= TW'(1);
        ovf_r  <= 1'b0;
        best_r <= e_d_r;
      end else if (e_v_r && tie) begin
        if (32'(tcnt_r) < MAX_TIES) tcnt_r <= tcnt_r + TW'(1);
        else ovf_r <= 1'b1;
      end
      if ((state_r == ST_EMLD || state_r == ST_NONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    // query setup and scan index
    if (cmd_pop) begin
      guess_r <= cmd.guess;
      gok_r   <= 32'(cmd.cid) < MAX_CELLS;
      gcell_r <= CAW'(cmd.cid);
      tx_r    <= CB'(cmd.x);
      ty_r    <= CB'(cmd.y);
      tz_r    <= CB'(cmd.z);
      n_r     <= (32'(num_cells) > MAX_CELLS) ? IW'(MAX_CELLS) : IW'(num_cells);
      i_r     <= '0;
    end else if (issue) begin
      i_r <= i_r + IW'(1);
    end

    // store writes
    if (cmd_pop && cmd.kind == REQ_WR_POINT && 32'(cmd.cid) < MAX_CELLS) begin
      pt_mem[CAW'(cmd.cid)] <= {CB'(cmd.z), CB'(cmd.y), CB'(cmd.x)};
    end
    if (cmd_pop && cmd.kind == REQ_WR_NB && 32'(cmd.cid) < MAX_CELLS &&
        32'(cmd.slot) < MAX_NEIGHBOURS) begin
      nb_mem[{CAW'(cmd.cid), SW'(cmd.slot)}] <= cmd.nb;
    end
    if (state_r == ST_CLEAR) begin
      cnt_mem[clr_r] <= '0;
    end else if (cmd_pop && cmd.kind == REQ_WR_NB && 32'(cmd.cid) < MAX_CELLS) begin
      cnt_mem[CAW'(cmd.cid)] <= NCW'(cmd.cnt);
    end

    // stage a: candidate and neighbour fetch
    if (state_r == ST_CNT) begin
      cnt_q_r  <= cnt_mem[gcell_r];
      a_nb_r   <= 1'b0;
      a_cell_r <= CW'(gcell_r);
    end else begin
      a_nb_r   <= guess_r;
      a_cell_r <= CW'(i_r);
    end
    if (issue) begin
      nb_q_r <= nb_mem[{gcell_r, SW'(i_r)}];
    end

    // stage b: point fetch
    b_cell_r <= b_cell;
    if (a_v_r && b_ok) begin
      pt_q_r <= pt_mem[CAW'(b_cell)];
    end

    // stage c: absolute differences
    c_cell_r <= b_cell_r;
    c_ax_r   <= ax;
    c_ay_r   <= ay;
    c_az_r   <= az;
    c_sat_r  <= (64'(ax) >= 64'h2000000) || (64'(ay) >= 64'h2000000) ||
                (64'(az) >= 64'h2000000);

    // stage d: squares
    d_cell_r <= c_cell_r;
    d_sat_r  <= c_sat_r;
    d_sx_r   <= SQ'(c_ax_r) * SQ'(c_ax_r);
    d_sy_r   <= SQ'(c_ay_r) * SQ'(c_ay_r);
    d_sz_r   <= SQ'(c_az_r) * SQ'(c_az_r);

    // stage e: sum with saturation
    e_cell_r <= d_cell_r;
    e_d_r    <= (d_sat_r || sum > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);

    if (tb_we) begin
      tb_mem[tb_wa] <= CELL_W'(e_cell_r);
    end

    // result emission
    if (state_r == ST_EMRD) begin
      tb_q_r <= tb_mem[TAW'(em_r)];
    end
    if (cmd_pop) begin
      em_r <= '0;
    end else if (state_r == ST_EMLD && out_free) begin
      em_r <= em_r + TW'(1);
    end
    if (state_r == ST_EMLD && out_free) begin
      out_r.closest_cell <= tb_q_r;
      out_r.min_distance <= best_r;
      out_r.found        <= 1'b1;
      out_r.overflow     <= ovf_r;
      out_r.is_last      <= (em_r + TW'(1) == tcnt_r);
    end else if (state_r == ST_NONE && out_free) begin
      out_r.closest_cell <= '0;
      out_r.min_distance <= DIST_MAX;
      out_r.found        <= 1'b0;
      out_r.overflow     <= 1'b0;
      out_r.is_last      <= 1'b1;
    end
  end

endmodule

### hw/rtl/nearest_cell_search_with_ties.sv
// ============================================================================
// nearest_cell_search_with_ties
// 3d nearest cell search over a stored point table, reporting tied cells
//
// beats on in_ carry point writes, neighbour slot writes and queries; an
// accepted beat enters a two-entry command queue, so the input keeps taking
// beats while the scan unit is busy, until the queue fills and in_stall rises.
// a write goes into the stores as the scan unit takes it from the queue.
// a query scans either cells 0 .. num_cells-1 or the guess cell and its
// neighbours, one distance per cycle through a five-stage distance
// pipeline, then reads each result beat from the tie buffer. each tied
// cell, up to MAX_TIES, comes out as one out_ beat, is_last on the final
// one; a query with no candidate gives one beat with found low.
// out_ beats sit in an output register; while out_stall is high the beat
// holds and the scan unit waits before the next result.
// after reset the neighbour count table is cleared entry by entry,
// during which no command leaves the queue; cfg_ writes are taken at any
// time and must only be issued while the block is idle.
// ============================================================================
module nearest_cell_search_with_ties #(
  parameter int MAX_CELLS      = ncs_pkg::MAX_CELLS_DEF,
  parameter int MAX_NEIGHBOURS = ncs_pkg::MAX_NEIGHBOURS_DEF,
  parameter int MAX_TIES       = ncs_pkg::MAX_TIES_DEF,
  parameter int COORD_BITS     = ncs_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ncs_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ncs_pkg::out_beat_t        out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ncs_pkg::TOL_W-1:0] cfg_wdata
);
  import ncs_pkg::*;

  logic [NUMC_W-1:0] num_cells_r;
  logic [TOL_W-1:0]  tie_tol_r;
  logic              fr_valid, q_full, q_empty, q_pop;
  cmd_t              fr_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cells_r <= '0;
      tie_tol_r   <= TOL_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_CELLS) num_cells_r <= NUMC_W'(cfg_wdata);
      if (cfg_index == CFG_TIE_TOL) tie_tol_r <= cfg_wdata;
    end
  end

  ncs_front #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_valid(fr_valid),
    .cmd_full (q_full),
    .cmd      (fr_cmd)
  );

  ncs_fifo #(
    .W($bits(cmd_t))
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fr_valid),
    .wdata(fr_cmd),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_cmd)
  );

  ncs_back #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
    .MAX_TIES      (MAX_TIES),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(q_empty),
    .cmd      (q_cmd),
    .cmd_pop  (q_pop),
    .num_cells(num_cells_r),
    .tie_tol  (tie_tol_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
